// ===== rtl/core/esseg_pkg.sv =====
// Shared types and constants of the energy silence segmenter.
package esseg_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SQUARE_W    = 31;
   localparam int ENERGY_W    = 41;
   localparam int THRESHOLD_W = 31;
   localparam int LIMIT_W     = 16;
   localparam int QUIET_W     = 17;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 31;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 31'd107374182;
   localparam logic [LIMIT_W-1:0]     LIMIT_RESET     = 16'd5;
   localparam logic [ENERGY_W-1:0]    ENERGY_MAX      = {ENERGY_W{1'b1}};
   localparam logic [QUIET_W-1:0]     QUIET_MAX       = {QUIET_W{1'b1}};

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_THRESHOLD   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_QUIET_LIMIT = 1'b1;

   // Input command codes.
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_EOS    = 1'b1;

   typedef struct packed {
      logic                valid;
      logic                command;
      logic                last;
      logic [SQUARE_W-1:0] square;
   } esseg_stage_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] buffer_energy;
      logic                joined_segment;
      logic [QUIET_W-1:0]  quiet_run;
      logic                segment_end;
   } esseg_result_type;

endpackage

// ===== rtl/core/esseg_if.sv =====
// Valid/ready channel interfaces for the segmenter's input and result items.
interface esseg_req_if
   import esseg_pkg::*;
();
   logic                valid;
   logic                ready;
   logic                command;
   logic [SAMPLE_W-1:0] sample;
   logic                last_in_buffer;

   modport source (output valid, command, sample, last_in_buffer, input ready);
   modport sink   (input valid, command, sample, last_in_buffer, output ready);
endinterface

interface esseg_rsp_if
   import esseg_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [ENERGY_W-1:0] buffer_energy;
   logic                joined_segment;
   logic [QUIET_W-1:0]  quiet_run;
   logic                segment_end;

   modport source (output valid, buffer_energy, joined_segment, quiet_run, segment_end,
                   input ready);
   modport sink   (input valid, buffer_energy, joined_segment, quiet_run, segment_end,
                   output ready);
endinterface

// ===== rtl/core/energy_silence_segmenter_core.sv =====
// Top level of the energy silence segmenter.
//
//   Channel   Kind           Moves
//   req_bus   valid/ready    command, sample, last_in_buffer (one item per sample)
//   rsp_bus   valid/ready    buffer_energy, joined_segment, quiet_run, segment_end
//   csr_*     write only     energy_threshold (index 0), quiet_limit (index 1)
//
// One item is accepted per cycle unless input stalls. The sample is squared on
// its way into the input register; once the result buffer has room, the decide
// stage folds it into the accumulator and segment state and writes the result
// into the buffer, which raises rsp_bus.valid for the closing item. A two-entry
// result buffer keeps input acceptance going while a result waits; input stalls
// only once both entries and the input register are full. Reset is synchronous
// and restores the register defaults and an empty, closed state.
module energy_silence_segmenter_core
   import esseg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   esseg_req_if.sink              req_bus,
   esseg_rsp_if.source            rsp_bus,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   esseg_stage_type  stage;
   esseg_result_type result;
   esseg_result_type rsp_data;
   logic             advance;
   logic             res_valid;

   esseg_square u_square (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (req_bus.valid),
      .in_ready       (req_bus.ready),
      .command        (req_bus.command),
      .sample         (req_bus.sample),
      .last_in_buffer (req_bus.last_in_buffer),
      .stage          (stage)
   );

   esseg_decide u_decide (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .stage            (stage),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .res_valid        (res_valid),
      .result           (result)
   );

   esseg_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (res_valid),
      .wr_data  (result),
      .room     (advance),
      .rd_valid (rsp_bus.valid),
      .rd_ready (rsp_bus.ready),
      .rd_data  (rsp_data)
   );

   assign rsp_bus.buffer_energy  = rsp_data.buffer_energy;
   assign rsp_bus.joined_segment = rsp_data.joined_segment;
   assign rsp_bus.quiet_run      = rsp_data.quiet_run;
   assign rsp_bus.segment_end    = rsp_data.segment_end;

endmodule

// ===== rtl/core/esseg_square.sv =====
// Input register stage: captures an item and squares its sample.
module esseg_square
   import esseg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                command,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic                last_in_buffer,
   output esseg_stage_type     stage
);

   logic                valid_ff, valid_in;
   logic                command_ff;
   logic                last_ff;
   logic [SQUARE_W-1:0] square_ff;
   logic [2*SAMPLE_W-1:0] product;
   logic                load;

   assign in_ready = !valid_ff || advance;
   assign load     = in_valid && in_ready;
   assign product  = (2*SAMPLE_W)'($signed(sample)) * (2*SAMPLE_W)'($signed(sample));

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         command_ff <= command;
         last_ff    <= last_in_buffer;
         // The square of any 16-bit value is at most 2^30, so 31 bits hold it.
         square_ff  <= product[SQUARE_W-1:0];
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.command = command_ff;
   assign stage.last    = last_ff;
   assign stage.square  = square_ff;

endmodule

// ===== rtl/core/esseg_decide.sv =====
// Accumulator, threshold compare and segment state, plus the configuration registers.
module esseg_decide
   import esseg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  esseg_stage_type        stage,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output logic                   res_valid,
   output esseg_result_type       result
);

   logic [THRESHOLD_W-1:0] threshold_ff;
   logic [LIMIT_W-1:0]     limit_ff;
   logic [ENERGY_W-1:0]    sum_ff, sum_in;
   logic                   open_ff, open_in;
   logic [QUIET_W-1:0]     quiet_ff, quiet_in;

   logic                   fire;
   logic [ENERGY_W:0]      sum_wide;
   logic [ENERGY_W-1:0]    energy;
   logic [ENERGY_W-1:0]    threshold_ext;
   logic                   above, below, joined, ended;
   logic [QUIET_W-1:0]     quiet_mid;

   assign fire          = stage.valid && advance;
   assign sum_wide      = {1'b0, sum_ff} + (ENERGY_W+1)'(stage.square);
   assign energy        = sum_wide[ENERGY_W] ? ENERGY_MAX : sum_wide[ENERGY_W-1:0];
   assign threshold_ext = ENERGY_W'(threshold_ff);
   assign above         = energy > threshold_ext;
   assign below         = energy < threshold_ext;
   assign joined        = above || open_ff;

   always_comb begin
      if (below && joined) begin
         quiet_mid = (quiet_ff == QUIET_MAX) ? quiet_ff : quiet_ff + QUIET_W'(1);
      end else begin
         quiet_mid = '0;
      end
   end

   assign ended = joined && (quiet_mid > QUIET_W'(limit_ff));

   always_comb begin
      sum_in    = sum_ff;
      open_in   = open_ff;
      quiet_in  = quiet_ff;
      res_valid = 1'b0;
      result    = '0;
      if (fire) begin
         if (stage.command == CMD_EOS) begin
            // End of stream drops a partial buffer and closes an open segment.
            sum_in = '0;
            if (open_ff) begin
               open_in            = 1'b0;
               quiet_in           = '0;
               res_valid          = 1'b1;
               result.segment_end = 1'b1;
            end
         end else if (!stage.last) begin
            sum_in = energy;
         end else begin
            sum_in                = '0;
            open_in               = joined && !ended;
            quiet_in              = ended ? '0 : quiet_mid;
            res_valid             = 1'b1;
            result.buffer_energy  = energy;
            result.joined_segment = joined;
            result.quiet_run      = ended ? '0 : quiet_mid;
            result.segment_end    = ended;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         limit_ff     <= LIMIT_RESET;
         sum_ff       <= '0;
         open_ff      <= 1'b0;
         quiet_ff     <= '0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_THRESHOLD:   threshold_ff <= csr_write_data[THRESHOLD_W-1:0];
               CSR_QUIET_LIMIT: limit_ff     <= csr_write_data[LIMIT_W-1:0];
               default: ;
            endcase
         end
         sum_ff   <= sum_in;
         open_ff  <= open_in;
         quiet_ff <= quiet_in;
      end
   end

endmodule

// ===== rtl/core/esseg_out_buf.sv =====
// Two-entry result buffer that decouples the result channel from the pipeline.
module esseg_out_buf
   import esseg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  esseg_result_type wr_data,
   output logic             room,
   output logic             rd_valid,
   input  logic             rd_ready,
   output esseg_result_type rd_data
);

   esseg_result_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             rd_en;

   assign room     = count_ff != 2'd2;
   assign rd_valid = count_ff != 2'd0;
   assign rd_en    = rd_valid && rd_ready;
   assign rd_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = rd_en ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(wr_en) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
